/* rtl/dbat_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dbat_pkg;

  // Lexer token kinds; codes above TK_OTHER are folded into TK_OTHER.
  typedef enum logic [4:0] {
    TK_LSQ    = 5'd0,
    TK_RSQ    = 5'd1,
    TK_IDENT  = 5'd2,
    TK_LPAREN = 5'd3,
    TK_RPAREN = 5'd4,
    TK_AT     = 5'd5,
    TK_EQ     = 5'd6,
    TK_COMMA  = 5'd7,
    TK_STRING = 5'd8,
    TK_NUMBER = 5'd9,
    TK_FALSE  = 5'd10,
    TK_TRUE   = 5'd11,
    TK_SLASH  = 5'd12,
    TK_STAR   = 5'd13,
    TK_PLUS   = 5'd14,
    TK_MINUS  = 5'd15,
    TK_OTHER  = 5'd16
  } tok_t;

  typedef enum logic [2:0] {
    ROLE_NONE  = 3'd0,
    ROLE_OPEN  = 3'd1,
    ROLE_NAME  = 3'd2,
    ROLE_PARAM = 3'd3,
    ROLE_CLOSE = 3'd4
  } role_t;

  // Parse position, one-hot.
  typedef enum logic [6:0] {
    POS_SEARCH = 7'b0000001,
    POS_OPEN2  = 7'b0000010,
    POS_NAME   = 7'b0000100,
    POS_AFTER  = 7'b0001000,
    POS_PARAMS = 7'b0010000,
    POS_CLOSE1 = 7'b0100000,
    POS_CLOSE2 = 7'b1000000
  } pos_t;

  typedef struct packed {
    role_t role;
    logic  complete;
    logic  abandoned;
    logic  error;
  } res_t;

endpackage

`default_nettype wire

/* rtl/dbat_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface dbat_in_if;
  logic       valid;
  logic       ready;
  logic [4:0] token_kind;
  logic       stream_start;

  modport source (output valid, output token_kind, output stream_start, input ready);
  modport sink   (input valid, input token_kind, input stream_start, output ready);
endinterface

`default_nettype wire

/* rtl/dbat_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface dbat_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] token_role;
  logic       attr_complete;
  logic       attr_abandoned;
  logic       parse_error;

  modport source (output valid, output token_role, output attr_complete,
                  output attr_abandoned, output parse_error, input ready);
  modport sink   (input valid, input token_role, input attr_complete,
                  input attr_abandoned, input parse_error, output ready);
endinterface

`default_nettype wire

/* rtl/double_bracket_attribute_token_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

// Finds [[name]] and [[name(params)]] attributes in a lexer token stream, one
// token kind per item, and returns one result item per token: its role, and
// flags for a completed attribute, an attribute dropped on a bracket mismatch,
// and a sticky parse error (malformed attribute or parenthesis nesting deeper
// than MAX_NEST). An item with stream_start set restarts the parse and clears
// the error before its token is looked at. Throughput is one item per clock
// while the output queue is not full: the parse position, nesting depth and
// error flag are updated in the cycle an item is accepted, and its result is
// written into a two-entry output queue; with no earlier result waiting, it
// appears on out_ch the cycle after acceptance. in_ch.ready depends only on
// the queue fill: waiting results stall the input only once the queue holds two.
module double_bracket_attribute_token_parser #(
  parameter int MAX_NEST = 15
) (
  input  wire        clk,
  input  wire        rst_n,
  dbat_in_if.sink    in_ch,
  dbat_out_if.source out_ch
);

  localparam int NEST_W = $clog2(MAX_NEST + 1);
  localparam logic [NEST_W-1:0] NEST_MAX = NEST_W'(MAX_NEST);

  // parse state
  dbat_pkg::pos_t    pos_r, pos_nxt;
  logic [NEST_W-1:0] depth_r, depth_nxt;
  logic              err_r, err_nxt;

  // output queue
  dbat_pkg::res_t q_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     cnt_r, cnt_nxt;

  dbat_pkg::res_t    res_nxt;
  dbat_pkg::tok_t    tk;
  dbat_pkg::pos_t    pos_b;
  logic [NEST_W-1:0] depth_b, depth_dec;
  logic              err_b;
  logic              fault;
  logic              push, pop;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = out_ch.valid && out_ch.ready;

  // Fold unused codes into "other".
  assign tk = (in_ch.token_kind > dbat_pkg::TK_OTHER) ? dbat_pkg::TK_OTHER
                                                      : dbat_pkg::tok_t'(in_ch.token_kind);

  // Restart applies before the token is parsed.
  assign pos_b     = in_ch.stream_start ? dbat_pkg::POS_SEARCH : pos_r;
  assign depth_b   = in_ch.stream_start ? '0 : depth_r;
  assign err_b     = in_ch.stream_start ? 1'b0 : err_r;
  assign depth_dec = depth_b - NEST_W'(depth_b != '0);

  always_comb begin
    pos_nxt           = pos_b;
    depth_nxt         = depth_b;
    fault             = 1'b0;
    res_nxt.role      = dbat_pkg::ROLE_NONE;
    res_nxt.complete  = 1'b0;
    res_nxt.abandoned = 1'b0;

    if (!err_b) begin
      unique case (pos_b)
        dbat_pkg::POS_OPEN2: begin
          if (tk == dbat_pkg::TK_LSQ) begin
            res_nxt.role = dbat_pkg::ROLE_OPEN;
            pos_nxt      = dbat_pkg::POS_NAME;
          end else begin
            // mismatch: drop partial attribute, token is consumed
            pos_nxt           = dbat_pkg::POS_SEARCH;
            depth_nxt         = '0;
            res_nxt.abandoned = 1'b1;
          end
        end
        dbat_pkg::POS_NAME: begin
          if (tk == dbat_pkg::TK_IDENT) begin
            res_nxt.role = dbat_pkg::ROLE_NAME;
            pos_nxt      = dbat_pkg::POS_AFTER;
          end else begin
            fault = 1'b1;
          end
        end
        dbat_pkg::POS_AFTER: begin
          priority if (tk == dbat_pkg::TK_LPAREN && depth_b < NEST_MAX) begin
            res_nxt.role = dbat_pkg::ROLE_PARAM;
            depth_nxt    = depth_b + NEST_W'(1);
            pos_nxt      = dbat_pkg::POS_PARAMS;
          end else if (tk == dbat_pkg::TK_RSQ) begin
            res_nxt.role = dbat_pkg::ROLE_CLOSE;
            pos_nxt      = dbat_pkg::POS_CLOSE2;
          end else begin
            fault = 1'b1;
          end
        end
        dbat_pkg::POS_PARAMS: begin
          priority if (tk == dbat_pkg::TK_RPAREN) begin
            res_nxt.role = dbat_pkg::ROLE_PARAM;
            depth_nxt    = depth_dec;
            if (depth_dec == '0) begin
              pos_nxt = dbat_pkg::POS_CLOSE1;
            end
          end else if (tk == dbat_pkg::TK_LPAREN) begin
            if (depth_b < NEST_MAX) begin
              res_nxt.role = dbat_pkg::ROLE_PARAM;
              depth_nxt    = depth_b + NEST_W'(1);
            end else begin
              fault = 1'b1;  // nesting overflow
            end
          end else if (tk != dbat_pkg::TK_OTHER) begin
            // brackets inside params count as parameter tokens too
            res_nxt.role = dbat_pkg::ROLE_PARAM;
          end else begin
            fault = 1'b1;
          end
        end
        dbat_pkg::POS_CLOSE1: begin
          if (tk == dbat_pkg::TK_RSQ) begin
            res_nxt.role = dbat_pkg::ROLE_CLOSE;
            pos_nxt      = dbat_pkg::POS_CLOSE2;
          end else begin
            pos_nxt           = dbat_pkg::POS_SEARCH;
            depth_nxt         = '0;
            res_nxt.abandoned = 1'b1;
          end
        end
        dbat_pkg::POS_CLOSE2: begin
          if (tk == dbat_pkg::TK_RSQ) begin
            res_nxt.role     = dbat_pkg::ROLE_CLOSE;
            res_nxt.complete = 1'b1;
            pos_nxt          = dbat_pkg::POS_SEARCH;
            depth_nxt        = '0;
          end else begin
            pos_nxt           = dbat_pkg::POS_SEARCH;
            depth_nxt         = '0;
            res_nxt.abandoned = 1'b1;
          end
        end
        default: begin
          // search for first '[' (also recovers from an illegal code)
          if (tk == dbat_pkg::TK_LSQ) begin
            res_nxt.role = dbat_pkg::ROLE_OPEN;
            pos_nxt      = dbat_pkg::POS_OPEN2;
          end else begin
            pos_nxt = dbat_pkg::POS_SEARCH;
          end
        end
      endcase
    end

    if (fault) begin
      pos_nxt   = dbat_pkg::POS_SEARCH;
      depth_nxt = '0;
    end
    err_nxt       = err_b | fault;
    res_nxt.error = err_nxt;
  end

  always_comb begin
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= dbat_pkg::POS_SEARCH;
      depth_r  <= '0;
      err_r    <= 1'b0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        pos_r    <= pos_nxt;
        depth_r  <= depth_nxt;
        err_r    <= err_nxt;
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // queue payload, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= res_nxt;
    end
  end

  assign out_ch.valid          = (cnt_r != 2'd0);
  assign out_ch.token_role     = q_r[rd_ptr_r].role;
  assign out_ch.attr_complete  = q_r[rd_ptr_r].complete;
  assign out_ch.attr_abandoned = q_r[rd_ptr_r].abandoned;
  assign out_ch.parse_error    = q_r[rd_ptr_r].error;

  // A latched error always leaves the parser parked in search with no depth.
  a_err_parked: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> (pos_r == dbat_pkg::POS_SEARCH && depth_r == '0))
    else $error("error latched with live parse state");

  // Open parentheses only exist while inside params.
  a_depth_params: assert property (@(posedge clk) disable iff (!rst_n)
    (depth_r != '0) |-> (pos_r == dbat_pkg::POS_PARAMS && depth_r <= NEST_MAX))
    else $error("nesting depth outside params or above bound");

  // A completed attribute returns the parser to search.
  a_done_search: assert property (@(posedge clk) disable iff (!rst_n)
    (push && res_nxt.complete) |=> (pos_r == dbat_pkg::POS_SEARCH && depth_r == '0))
    else $error("parser not back in search after completion");

  // Queue fill tracks pushes and pops.
  a_queue_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != 2'd3) && ((wr_ptr_r ^ rd_ptr_r) == cnt_r[0]))
    else $error("output queue fill inconsistent with pointers");

endmodule

`default_nettype wire

/* tb/tb_double_bracket_attribute_token_parser.sv */
`timescale 1ns / 1ps

module tb_double_bracket_attribute_token_parser;

  localparam int NEST_LIMIT  = 15;
  localparam int PHASE_ITEMS = 325;      // four phases, about 1300 items in all
  localparam int CYCLE_LIMIT = 400000;   // far above the slowest legal run

  // One token item as the sender presents it.
  typedef struct {
    logic [4:0] kind;
    logic       restart;
  } tok_item_t;

  logic clk;
  logic rst_n;

  dbat_in_if  in_ch ();
  dbat_out_if out_ch ();

  double_bracket_attribute_token_parser #(
    .MAX_NEST(NEST_LIMIT)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Tokens waiting to be sent, and role marks waiting to come back.
  tok_item_t      tok_q[$];
  dbat_pkg::res_t role_q[$];

  // Parser state as the scoreboard sees it.
  dbat_pkg::pos_t attr_pos    = dbat_pkg::POS_SEARCH;
  int unsigned    paren_depth = 0;
  bit             err_held    = 1'b0;

  int unsigned send_idle_pct   = 0;
  int unsigned ready_stall_pct = 0;
  int unsigned items_queued    = 0;
  int unsigned results_checked = 0;
  int unsigned fail_cnt        = 0;
  int unsigned cycles_run      = 0;
  bit          tok_fired       = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Steps the scoreboard copy of the parser by one token and returns the
  // result item the block should produce for it.
  function automatic dbat_pkg::res_t parse_token(input logic [4:0] raw,
                                                 input logic restart);
    dbat_pkg::res_t r;
    dbat_pkg::tok_t tk;
    bit             bad;
    bit             mismatch;
    r        = '{dbat_pkg::ROLE_NONE, 1'b0, 1'b0, 1'b0};
    bad      = 1'b0;
    mismatch = 1'b0;
    // codes past "other" are treated as "other"
    tk = (raw > dbat_pkg::TK_OTHER) ? dbat_pkg::TK_OTHER : dbat_pkg::tok_t'(raw);
    if (restart) begin
      attr_pos    = dbat_pkg::POS_SEARCH;
      paren_depth = 0;
      err_held    = 1'b0;
    end
    // a held error swallows everything until the next restart
    if (!err_held) begin
      case (attr_pos)
        dbat_pkg::POS_OPEN2: begin
          if (tk == dbat_pkg::TK_LSQ) begin
            r.role   = dbat_pkg::ROLE_OPEN;
            attr_pos = dbat_pkg::POS_NAME;
          end else begin
            mismatch = 1'b1;
          end
        end
        dbat_pkg::POS_NAME: begin
          if (tk == dbat_pkg::TK_IDENT) begin
            r.role   = dbat_pkg::ROLE_NAME;
            attr_pos = dbat_pkg::POS_AFTER;
          end else begin
            bad = 1'b1;
          end
        end
        dbat_pkg::POS_AFTER: begin
          if (tk == dbat_pkg::TK_LPAREN && paren_depth < NEST_LIMIT) begin
            r.role      = dbat_pkg::ROLE_PARAM;
            paren_depth = paren_depth + 1;
            attr_pos    = dbat_pkg::POS_PARAMS;
          end else if (tk == dbat_pkg::TK_RSQ) begin
            r.role   = dbat_pkg::ROLE_CLOSE;
            attr_pos = dbat_pkg::POS_CLOSE2;
          end else begin
            bad = 1'b1;
          end
        end
        dbat_pkg::POS_PARAMS: begin
          if (tk == dbat_pkg::TK_RPAREN) begin
            r.role = dbat_pkg::ROLE_PARAM;
            if (paren_depth > 0) paren_depth = paren_depth - 1;
            if (paren_depth == 0) attr_pos = dbat_pkg::POS_CLOSE1;
          end else if (tk == dbat_pkg::TK_LPAREN) begin
            // one level too deep is a malformed token
            if (paren_depth < NEST_LIMIT) begin
              r.role      = dbat_pkg::ROLE_PARAM;
              paren_depth = paren_depth + 1;
            end else begin
              bad = 1'b1;
            end
          end else if (tk != dbat_pkg::TK_OTHER) begin
            r.role = dbat_pkg::ROLE_PARAM;    // square brackets count as params here
          end else begin
            bad = 1'b1;
          end
        end
        dbat_pkg::POS_CLOSE1: begin
          if (tk == dbat_pkg::TK_RSQ) begin
            r.role   = dbat_pkg::ROLE_CLOSE;
            attr_pos = dbat_pkg::POS_CLOSE2;
          end else begin
            mismatch = 1'b1;
          end
        end
        dbat_pkg::POS_CLOSE2: begin
          if (tk == dbat_pkg::TK_RSQ) begin
            r.role      = dbat_pkg::ROLE_CLOSE;
            r.complete  = 1'b1;
            attr_pos    = dbat_pkg::POS_SEARCH;
            paren_depth = 0;
          end else begin
            mismatch = 1'b1;
          end
        end
        default: begin
          if (tk == dbat_pkg::TK_LSQ) begin
            r.role   = dbat_pkg::ROLE_OPEN;
            attr_pos = dbat_pkg::POS_OPEN2;
          end else begin
            attr_pos = dbat_pkg::POS_SEARCH;
          end
        end
      endcase
      // the offending token is consumed, not looked at again
      if (bad) begin
        err_held    = 1'b1;
        attr_pos    = dbat_pkg::POS_SEARCH;
        paren_depth = 0;
      end
      if (mismatch) begin
        r.abandoned = 1'b1;
        attr_pos    = dbat_pkg::POS_SEARCH;
        paren_depth = 0;
      end
    end
    r.error = err_held;
    return r;
  endfunction

  task automatic push_tok(input logic [4:0] kind, input logic restart);
    tok_q.insert(tok_q.size(), '{kind, restart});
    items_queued++;
  endtask

  // One random token run: mostly well-formed attributes with random params,
  // some cut short or with a corrupted token, some deep nests just below, at and
  // past the limit, and some plain noise over all 32 codes.
  task automatic gen_sequence();
    logic [4:0]  seq[$];
    int unsigned pick;
    int unsigned depth;
    int unsigned n;
    int unsigned k;
    int unsigned cut;
    bit          lead_restart;
    pick = $urandom_range(99);
    if (pick < 20) begin
      n = $urandom_range(1, 6);
      repeat (n) seq.insert(seq.size(), 5'($urandom_range(31)));
    end else if (pick < 30) begin
      k = $urandom_range(NEST_LIMIT - 2, NEST_LIMIT + 1);
      seq.insert(seq.size(), dbat_pkg::TK_LSQ);
      seq.insert(seq.size(), dbat_pkg::TK_LSQ);
      seq.insert(seq.size(), dbat_pkg::TK_IDENT);
      repeat (k) seq.insert(seq.size(), dbat_pkg::TK_LPAREN);
      repeat (k) seq.insert(seq.size(), dbat_pkg::TK_RPAREN);
      seq.insert(seq.size(), dbat_pkg::TK_RSQ);
      seq.insert(seq.size(), dbat_pkg::TK_RSQ);
    end else begin
      seq.insert(seq.size(), dbat_pkg::TK_LSQ);
      seq.insert(seq.size(), dbat_pkg::TK_LSQ);
      seq.insert(seq.size(), dbat_pkg::TK_IDENT);
      if ($urandom_range(2) != 0) begin
        seq.insert(seq.size(), dbat_pkg::TK_LPAREN);
        depth = 1;
        n = $urandom_range(0, 8);
        repeat (n) begin
          k = $urandom_range(9);
          if (k < 2 && depth < 4) begin
            seq.insert(seq.size(), dbat_pkg::TK_LPAREN);
            depth++;
          end else if (k < 4 && depth > 1) begin
            seq.insert(seq.size(), dbat_pkg::TK_RPAREN);
            depth--;
          end else begin
            // any param token: 0..2 and 5..15
            k = $urandom_range(13);
            seq.insert(seq.size(), 5'((k < 3) ? k : k + 2));
          end
        end
        repeat (depth) seq.insert(seq.size(), dbat_pkg::TK_RPAREN);
      end
      seq.insert(seq.size(), dbat_pkg::TK_RSQ);
      seq.insert(seq.size(), dbat_pkg::TK_RSQ);
      // broken variant: truncate and corrupt the last kept token
      if (pick >= 85) begin
        cut = $urandom_range(seq.size() - 1);
        while (seq.size() > cut + 1) void'(seq.pop_back());
        seq[cut] = 5'($urandom_range(31));
      end
    end
    // restart often at a run boundary, rarely in the middle of one
    lead_restart = ($urandom_range(2) == 0);
    foreach (seq[i]) push_tok(seq[i], (i == 0) ? lead_restart : ($urandom_range(59) == 0));
  endtask

  // Sender and receiver: all inputs change on the falling edge.
  always @(negedge clk) begin : drive_blk
    tok_item_t nxt;
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= ready_stall_pct);
      // move on only once the current item has gone in
      if (!in_ch.valid || tok_fired) begin
        if (tok_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = tok_q.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.token_kind   <= nxt.kind;
          in_ch.stream_start <= nxt.restart;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: handshakes sampled on the rising edge.
  always @(posedge clk) begin : watch_blk
    dbat_pkg::res_t want;
    tok_fired = 1'b0;
    if (rst_n) begin
      tok_fired = in_ch.valid && in_ch.ready;
      if (tok_fired) begin
        role_q.insert(role_q.size(), parse_token(in_ch.token_kind, in_ch.stream_start));
      end
      if (out_ch.valid && out_ch.ready) begin
        results_checked++;
        if (role_q.size() == 0) begin
          $error("result item with no token pending: role %0d", out_ch.token_role);
          fail_cnt++;
        end else begin
          want = role_q.pop_front();
          if (out_ch.token_role !== want.role) begin
            $error("token_role: expected %0d, got %0d", want.role, out_ch.token_role);
            fail_cnt++;
          end
          if (out_ch.attr_complete !== want.complete) begin
            $error("attr_complete: expected %0d, got %0d", want.complete,
                   out_ch.attr_complete);
            fail_cnt++;
          end
          if (out_ch.attr_abandoned !== want.abandoned) begin
            $error("attr_abandoned: expected %0d, got %0d", want.abandoned,
                   out_ch.attr_abandoned);
            fail_cnt++;
          end
          if (out_ch.parse_error !== want.error) begin
            $error("parse_error: expected %0d, got %0d", want.error, out_ch.parse_error);
            fail_cnt++;
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles_run <= cycles_run + 1;
    if (cycles_run == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.token_kind   = '0;
    in_ch.stream_start = 1'b0;
    out_ch.ready       = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Phases: free running, sender gaps, receiver stalls, both.
    // Between phases the sender holds off until every result is back.
    for (int ph = 0; ph < 4; ph++) begin
      @(posedge clk);
      send_idle_pct   = (ph == 1) ? 74 : (ph == 3) ? 17 : 0;
      ready_stall_pct = (ph == 2) ? 74 : (ph == 3) ? 17 : 0;
      if (ph == 0) begin
        // full attribute with every param token kind, brackets included
        push_tok(dbat_pkg::TK_LSQ, 1'b1);
        push_tok(dbat_pkg::TK_LSQ, 1'b0);
        push_tok(dbat_pkg::TK_IDENT, 1'b0);
        push_tok(dbat_pkg::TK_LPAREN, 1'b0);
        for (int t = 0; t <= 15; t++)
          if (t != dbat_pkg::TK_LPAREN && t != dbat_pkg::TK_RPAREN) push_tok(t[4:0], 1'b0);
        push_tok(dbat_pkg::TK_RPAREN, 1'b0);
        push_tok(dbat_pkg::TK_RSQ, 1'b0);
        push_tok(dbat_pkg::TK_RSQ, 1'b0);
        // bracket mismatch right after the first open
        push_tok(dbat_pkg::TK_LSQ, 1'b0);
        push_tok(dbat_pkg::TK_RSQ, 1'b0);
        // top code where the name belongs, then a token under the held error
        push_tok(dbat_pkg::TK_LSQ, 1'b0);
        push_tok(dbat_pkg::TK_LSQ, 1'b0);
        push_tok(5'd31, 1'b0);
        push_tok(dbat_pkg::TK_OTHER, 1'b0);
      end
      while (items_queued < (ph + 1) * PHASE_ITEMS) gen_sequence();
      do @(negedge clk); while (results_checked != items_queued);
    end

    // spare wait to catch stray results
    repeat (8) @(negedge clk);
    if (role_q.size() != 0) begin
      $error("%0d expected results never arrived", role_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
